FILE: hdl/tlca_pkg.sv
// ----------------------------------------------------------------------------
// tlca_pkg: shared types and constants for the tree LCA block
// Node and depth widths, default sizes and the command codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tlca_pkg;

  localparam int NODE_W  = 13;
  localparam int DEPTH_W = 12;

  localparam int DEF_MAX_NODES   = 4096;
  localparam int DEF_LIFT_LEVELS = 12;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  localparam depth_t DEPTH_MAX = '1;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/tlca_if.sv
// ----------------------------------------------------------------------------
// tlca_if: valid/ready channels of the tree LCA block
// The command channel carries loads and queries; the result channel answers.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlca_in_if import tlca_pkg::*; ();
  logic  valid;
  logic  ready;
  cmd_t  command;
  node_t node_a;
  node_t node_b;

  modport source (output valid, output command, output node_a, output node_b,
                  input ready);
  modport sink (input valid, input command, input node_a, input node_b,
                output ready);
endinterface

interface tlca_out_if import tlca_pkg::*; ();
  logic  valid;
  logic  ready;
  node_t ancestor_node;

  modport source (output valid, output ancestor_node, input ready);
  modport sink (input valid, input ancestor_node, output ready);
endinterface

`default_nettype wire

FILE: hdl/tlca_ram.sv
// ----------------------------------------------------------------------------
// tlca_ram: one write port, two read ports, registered read data
// A read of the entry written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlca_ram #(
  parameter int DATA_W = 13,
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr0,
  input  wire logic [ADDR_W-1:0] raddr1,
  output logic      [DATA_W-1:0] rdata0,
  output logic      [DATA_W-1:0] rdata1
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= (we && waddr == raddr0) ? wdata : mem[raddr0];
    rdata1 <= (we && waddr == raddr1) ? wdata : mem[raddr1];
  end

endmodule

`default_nettype wire

FILE: hdl/tree_lca_binary_lifting_top.sv
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting_top: lowest common ancestor by binary lifting
// Loads parent links into an ancestor table and answers LCA queries.
// ----------------------------------------------------------------------------
// Load: writes the parent as level 0 and the depth, then the upper levels in order.
// Query: reads both depths, lifts the deeper node level by level from the top
//   down and then lifts both nodes together, each step set by the dependent
//   table reads; a pair that meets after the first lift skips the final lift,
//   and a query naming a non-node is answered with 0 without table reads.
// One item in work at a time; a result waits in the output register while the
//   next item is taken. Synchronous reset clears sequencer and output valid only.
`default_nettype none

module tree_lca_binary_lifting_top import tlca_pkg::*; #(
  parameter int MAX_NODES   = DEF_MAX_NODES,
  parameter int LIFT_LEVELS = DEF_LIFT_LEVELS
) (
  input  wire logic clk,
  input  wire logic rst,
  tlca_in_if.sink   in_chan,
  tlca_out_if.source out_chan
);

  // Row index into the tables and level index within a jump-table row.
  localparam int IDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int K_W    = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int JA_W   = IDX_W + K_W;
  // Width for the depth compare, which adds 2^k to a depth.
  localparam int SUMW   = ((DEPTH_W > LIFT_LEVELS) ? DEPTH_W : LIFT_LEVELS) + 1;
  localparam logic [K_W-1:0] K_TOP = K_W'(LIFT_LEVELS - 1);

  typedef logic [K_W-1:0] lvl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_L_DEP,
    S_L_JMP,
    S_Q_DEP,
    S_Q_LIFT,
    S_Q_LJ,
    S_Q_LD,
    S_Q_EQ,
    S_Q_UP,
    S_Q_FIN,
    S_EMIT
  } state_t;

  // A node code names a node when it lies in 1..MAX_NODES.
  function automatic logic node_ok(input node_t n);
    return (n != '0) && (32'(n) <= MAX_NODES);
  endfunction

  // Only non-root nodes have rows; the root and non-nodes read as
  // depth 0 with no ancestors.
  function automatic logic has_row(input node_t n);
    return (n > NODE_W'(1)) && (32'(n) <= MAX_NODES);
  endfunction

  function automatic logic [IDX_W-1:0] row_idx(input node_t n);
    return IDX_W'(n - NODE_W'(1));
  endfunction

  function automatic logic [JA_W-1:0] jaddr(input node_t n, input lvl_t k);
    return {row_idx(n), k};
  endfunction

  state_t state;
  node_t  a, b, res, out_data;
  depth_t da, db;
  lvl_t   k;
  logic   out_valid;

  // Nodes whose rows were addressed last cycle, for masking the read data.
  node_t  jn0_q, jn1_q, dn0_q, dn1_q;

  // Table ports.
  node_t             jn0, jn1, dn0, dn1;
  lvl_t              jk0, jk1;
  logic              jwe, dwe;
  logic [JA_W-1:0]   jwaddr;
  node_t             jwdata;
  logic [IDX_W-1:0]  dwaddr;
  depth_t            dwdata;
  node_t             jrd0, jrd1;
  depth_t            drd0, drd1;

  node_t  j0, j1, na, nb;
  depth_t dd0, dd1;
  logic   lift_cond, out_free, in_xfer;

  tlca_ram #(.DATA_W(NODE_W), .ADDR_W(JA_W)) u_jump_ram (
    .clk    (clk),
    .we     (jwe),
    .waddr  (jwaddr),
    .wdata  (jwdata),
    .raddr0 (jaddr(jn0, jk0)),
    .raddr1 (jaddr(jn1, jk1)),
    .rdata0 (jrd0),
    .rdata1 (jrd1)
  );

  tlca_ram #(.DATA_W(DEPTH_W), .ADDR_W(IDX_W)) u_depth_ram (
    .clk    (clk),
    .we     (dwe),
    .waddr  (dwaddr),
    .wdata  (dwdata),
    .raddr0 (row_idx(dn0)),
    .raddr1 (row_idx(dn1)),
    .rdata0 (drd0),
    .rdata1 (drd1)
  );

  // Entries of the root and of non-nodes read as zero.
  assign j0  = has_row(jn0_q) ? jrd0 : '0;
  assign j1  = has_row(jn1_q) ? jrd1 : '0;
  assign dd0 = has_row(dn0_q) ? drd0 : '0;
  assign dd1 = has_row(dn1_q) ? drd1 : '0;

  // First phase: lift a by 2^k while it stays at least that far below b.
  assign lift_cond = SUMW'(da) >= (SUMW'(db) + (SUMW'(1) << k));

  // Second phase: both move up only when both ancestors exist and differ.
  always_comb begin
    if (j0 != '0 && j1 != '0 && j0 != j1) begin
      na = j0;
      nb = j1;
    end else begin
      na = a;
      nb = b;
    end
  end

  // No command is taken while reset is held.
  assign in_chan.ready = (state == S_IDLE) && !rst;
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid || out_chan.ready;

  assign out_chan.valid         = out_valid;
  assign out_chan.ancestor_node = out_data;

  // Table addressing and writes for each step of the sequencer.
  always_comb begin
    jn0    = a;
    jk0    = k;
    jn1    = b;
    jk1    = k;
    dn0    = in_chan.node_a;
    dn1    = in_chan.node_b;
    jwe    = 1'b0;
    jwaddr = jaddr(a, k);
    jwdata = j0;
    dwe    = 1'b0;
    dwaddr = row_idx(a);
    dwdata = (dd1 == DEPTH_MAX) ? DEPTH_MAX : dd1 + DEPTH_W'(1);
    unique case (state)
      S_L_DEP: begin
        // Level 0 of the child's row is the parent itself.
        jwe    = 1'b1;
        jwaddr = jaddr(a, '0);
        jwdata = b;
        dwe    = 1'b1;
        jn0    = b;
        jk0    = '0;
      end
      S_L_JMP: begin
        // The level k-1 ancestor just read is level k of the child; its own
        // level k entry is the next one.
        jwe = 1'b1;
        jn0 = j0;
      end
      S_Q_LJ: begin
        dn0 = j0;
      end
      S_Q_EQ: begin
        jk0 = K_TOP;
        jk1 = K_TOP;
      end
      S_Q_UP: begin
        jn0 = na;
        jn1 = nb;
        jk0 = (k == '0) ? '0 : k - K_W'(1);
        jk1 = (k == '0) ? '0 : k - K_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    jn0_q <= jn0;
    jn1_q <= jn1;
    dn0_q <= dn0;
    dn1_q <= dn1;
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In the emit state the output register is handled below.
      if (out_valid && out_chan.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            a <= in_chan.node_a;
            b <= in_chan.node_b;
            if (in_chan.command == CMD_LOAD) begin
              // Loads naming a non-node or the root as child are dropped.
              if (node_ok(in_chan.node_a) && node_ok(in_chan.node_b) &&
                  in_chan.node_a != NODE_W'(1)) begin
                state <= S_L_DEP;
              end
            end else if (node_ok(in_chan.node_a) && node_ok(in_chan.node_b)) begin
              state <= S_Q_DEP;
            end else begin
              res   <= '0;
              state <= S_EMIT;
            end
          end
        end
        S_L_DEP: begin
          k     <= K_W'(1);
          state <= (LIFT_LEVELS > 1) ? S_L_JMP : S_IDLE;
        end
        S_L_JMP: begin
          if (k == K_TOP) begin
            state <= S_IDLE;
          end else begin
            k <= k + K_W'(1);
          end
        end
        S_Q_DEP: begin
          // Keep the deeper node in a.
          if (dd1 > dd0) begin
            a  <= b;
            b  <= a;
            da <= dd1;
            db <= dd0;
          end else begin
            da <= dd0;
            db <= dd1;
          end
          k     <= K_TOP;
          state <= S_Q_LIFT;
        end
        S_Q_LIFT: begin
          if (lift_cond) begin
            state <= S_Q_LJ;
          end else if (k == '0) begin
            state <= S_Q_EQ;
          end else begin
            k <= k - K_W'(1);
          end
        end
        S_Q_LJ: begin
          a     <= j0;
          state <= S_Q_LD;
        end
        S_Q_LD: begin
          da <= dd0;
          if (k == '0) begin
            state <= S_Q_EQ;
          end else begin
            k     <= k - K_W'(1);
            state <= S_Q_LIFT;
          end
        end
        S_Q_EQ: begin
          if (a == b) begin
            res   <= a;
            state <= S_EMIT;
          end else begin
            k     <= K_TOP;
            state <= S_Q_UP;
          end
        end
        S_Q_UP: begin
          a <= na;
          b <= nb;
          if (k == '0) begin
            state <= S_Q_FIN;
          end else begin
            k <= k - K_W'(1);
          end
        end
        S_Q_FIN: begin
          res   <= j0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tlca_checker.sv
// ----------------------------------------------------------------------------
// tlca_checker: port-level checks of the tree LCA block
// Watches the command and result channels; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tlca_checker import tlca_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  input wire logic  in_valid,
  input wire logic  in_ready,
  input wire cmd_t  in_command,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire node_t out_node
);

  // A stalled result keeps its value until it is transferred.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_node))
    else $error("result changed or dropped while stalled");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A query occupies the block: no new transfer the cycle after one.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_command == CMD_QUERY |=> !in_ready)
    else $error("command accepted during a query");

  // No result appears the cycle right after a command transfer.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result raised directly after a command transfer");

endmodule

bind tree_lca_binary_lifting_top tlca_checker u_tlca_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .in_command (in_chan.command),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_node   (out_chan.ancestor_node)
);

`default_nettype wire

FILE: verif/tlca_checker.sv
// ----------------------------------------------------------------------------
// tlca_scoreboard: scoreboard for the tree LCA block
// Watches both channels, keeps its own copy of the ancestor and depth tables,
// predicts the answer of every accepted query and compares each answer
// transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tlca_scoreboard import tlca_pkg::*; #(
  parameter int MAX_NODES   = DEF_MAX_NODES,
  parameter int LIFT_LEVELS = DEF_LIFT_LEVELS
) (
  input  logic clk,
  input  logic rst,
  tlca_in_if   in_mon,
  tlca_out_if  out_mon,
  output int   fail_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Row n holds the 2^k ancestors of node n; index 0 is unused.
  node_t       up_tbl    [MAX_NODES+1][LIFT_LEVELS];
  int unsigned depth_tbl [MAX_NODES+1];
  node_t       expected_ancestors [$];
  node_t       want;

  function automatic bit is_node(int unsigned n);
    return n >= 1 && n <= MAX_NODES;
  endfunction

  function automatic int unsigned depth_at(int unsigned n);
    return is_node(n) ? depth_tbl[n] : 0;
  endfunction

  function automatic int unsigned up_at(int unsigned n, int k);
    if (!is_node(n) || k >= LIFT_LEVELS) return 0;
    return up_tbl[n][k];
  endfunction

  // The row is rebuilt in place, so a node loaded under itself sees the
  // entries it has just written.
  function automatic void attach_child(int unsigned child, int unsigned parent);
    int unsigned d;
    int unsigned hop;
    if (!is_node(child) || !is_node(parent) || child == 1) return;
    d = depth_at(parent);
    d = (d >= DEPTH_MAX) ? DEPTH_MAX : d + 1;
    hop = parent;
    up_tbl[child][0] = node_t'(hop);
    for (int k = 1; k < LIFT_LEVELS; k++) begin
      hop = up_at(hop, k - 1);
      up_tbl[child][k] = node_t'(hop);
    end
    depth_tbl[child] = d;
  endfunction

  function automatic node_t lca_of(int unsigned a, int unsigned b);
    int unsigned t;
    int unsigned ja;
    int unsigned jb;
    if (!is_node(a) || !is_node(b)) return '0;
    if (depth_at(b) > depth_at(a)) begin
      t = a;
      a = b;
      b = t;
    end
    for (int k = LIFT_LEVELS - 1; k >= 0; k--) begin
      if (depth_at(a) >= depth_at(b) + (1 << k)) a = up_at(a, k);
    end
    if (a == b) return node_t'(a);
    for (int k = LIFT_LEVELS - 1; k >= 0; k--) begin
      ja = up_at(a, k);
      jb = up_at(b, k);
      if (ja != 0 && jb != 0 && ja != jb) begin
        a = ja;
        b = jb;
      end
    end
    return node_t'(up_at(a, 0));
  endfunction

  initial begin
    fail_count    = 0;
    pending_count = 0;
    for (int n = 0; n <= MAX_NODES; n++) begin
      depth_tbl[n] = 0;
      for (int k = 0; k < LIFT_LEVELS; k++) up_tbl[n][k] = '0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      expected_ancestors.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == CMD_LOAD) begin
          attach_child(in_mon.node_a, in_mon.node_b);
        end else begin
          expected_ancestors = {expected_ancestors,
                                lca_of(in_mon.node_a, in_mon.node_b)};
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_ancestors.size() == 0) begin
          $error("ancestor_node: no answer expected, actual %0d", out_mon.ancestor_node);
          fail_count++;
        end else begin
          want = expected_ancestors.pop_front();
          if (want !== out_mon.ancestor_node) begin
            $error("ancestor_node mismatch: expected %0d, actual %0d",
                   want, out_mon.ancestor_node);
            fail_count++;
          end
        end
      end
    end
    pending_count = expected_ancestors.size();
  end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the tree LCA block
// Builds trees through load transfers, asks lowest common ancestor queries,
// and leaves all prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb import tlca_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = DEF_MAX_NODES;

  logic clk = 1'b0;
  logic rst;

  tlca_in_if  in_chan ();
  tlca_out_if out_chan ();

  int fail_count;
  int pending_count;

  // Idle percentages for the two sides; the main sequence changes them.
  int tx_idle_pct = 32;
  int rx_idle_pct = 48;

  // A request for a long receiver hold-off; the receiver counts it down.
  bit hold_req = 1'b0;
  int hold_left = 0;

  // Nodes that have been given a parent (plus the root). Only these, or codes
  // that are not nodes, are ever used as a parent or as a query node, so no
  // table entry is read before it has been written.
  bit    known [1:NODES];
  node_t known_nodes [$];
  node_t last_loaded;

  tree_lca_binary_lifting_top u_top (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  tlca_scoreboard u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #60_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Receiver: ready changes at the falling edge. A hold-off request keeps it
  // low for a long stretch so the block fills up and stops taking commands.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // One command transfer. Idle cycles come first, then the item is held until
  // the block takes it. Valid only drops in an idle cycle, so it never gets
  // two assignments in one time step.
  task automatic send_item(input cmd_t cmd, input node_t a, input node_t b);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.command <= cmd;
    in_chan.node_a  <= a;
    in_chan.node_b  <= b;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Sends an item and tracks which nodes now have a parent.
  task automatic issue(input cmd_t cmd, input node_t a, input node_t b);
    if (cmd == CMD_LOAD && a >= 2 && a <= NODES && b >= 1 && b <= NODES) begin
      if (!known[a]) begin
        known[a] = 1'b1;
        known_nodes = {known_nodes, a};
      end
      last_loaded = a;
    end
    send_item(cmd, a, b);
  endtask

  function automatic node_t pick_known();
    return known_nodes[$urandom_range(known_nodes.size() - 1)];
  endfunction

  // Any code that is not a node: zero or above the table size.
  function automatic node_t pick_bad();
    return $urandom_range(1) ? node_t'(0) : node_t'($urandom_range(8191, NODES + 1));
  endfunction

  // A child for a well-formed load: mostly a new node, sometimes a reload.
  function automatic node_t pick_child();
    node_t n;
    if ($urandom_range(99) < 75) begin
      repeat (64) begin
        n = node_t'($urandom_range(NODES, 2));
        if (!known[n]) return n;
      end
    end
    repeat (8) begin
      n = pick_known();
      if (n != 1) return n;
    end
    return node_t'(2);
  endfunction

  // One random item. Loads that the block ignores are not counted.
  task automatic random_item(output bit counted);
    int    r;
    node_t a;
    node_t b;
    r = $urandom_range(99);
    counted = 1'b1;
    if (r < 40) begin
      // Parents favor the newest node so chains grow deep.
      a = pick_child();
      b = ($urandom_range(99) < 60) ? last_loaded : pick_known();
      issue(CMD_LOAD, a, b);
    end else if (r < 85) begin
      a = pick_known();
      b = ($urandom_range(9) == 0) ? a : pick_known();
      issue(CMD_QUERY, a, b);
    end else if (r < 92) begin
      a = pick_bad();
      b = $urandom_range(1) ? pick_known() : pick_bad();
      if ($urandom_range(1)) issue(CMD_QUERY, a, b);
      else issue(CMD_QUERY, b, a);
    end else begin
      counted = 1'b0;
      case ($urandom_range(2))
        0:       issue(CMD_LOAD, pick_bad(), pick_known());
        1:       issue(CMD_LOAD, pick_known(), pick_bad());
        default: issue(CMD_LOAD, node_t'(1), pick_known());
      endcase
    end
  endtask

  initial begin
    int n;
    bit counted;
    rst             = 1'b1;
    in_chan.valid   = 1'b0;
    in_chan.command = CMD_LOAD;
    in_chan.node_a  = '0;
    in_chan.node_b  = '0;
    for (int i = 1; i <= NODES; i++) known[i] = 1'b0;
    known[1] = 1'b1;
    known_nodes = {known_nodes, node_t'(1)};
    last_loaded = node_t'(1);

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed part: root against itself, a load of the root, a small tree
    // reaching the highest node code, out-of-range codes on either side,
    // a reload that leaves descendants alone, and a reload into a cycle.
    issue(CMD_QUERY, 1, 1);
    issue(CMD_LOAD, 1, 1);
    issue(CMD_LOAD, 2, 1);
    issue(CMD_LOAD, 3, 1);
    issue(CMD_LOAD, 4, 2);
    issue(CMD_LOAD, 5, 4);
    issue(CMD_LOAD, 4096, 5);
    issue(CMD_LOAD, 6, 3);
    issue(CMD_LOAD, 0, 1);
    issue(CMD_LOAD, 8191, 2);
    issue(CMD_LOAD, 7, 0);
    issue(CMD_LOAD, 7, 4097);
    issue(CMD_QUERY, 4096, 6);
    issue(CMD_QUERY, 5, 4096);
    issue(CMD_QUERY, 4096, 4);
    issue(CMD_QUERY, 2, 3);
    issue(CMD_QUERY, 0, 2);
    issue(CMD_QUERY, 2, 8191);
    issue(CMD_QUERY, 4096, 4096);
    issue(CMD_LOAD, 4, 3);
    issue(CMD_QUERY, 5, 6);
    issue(CMD_QUERY, 4, 5);
    issue(CMD_LOAD, 2, 5);
    issue(CMD_QUERY, 2, 4096);
    issue(CMD_QUERY, 6, 2);

    // Self-loads: a node loaded under itself gains one level each time and
    // reads back the row entries written in the same pass.
    issue(CMD_LOAD, 100, 1);
    repeat (20) issue(CMD_LOAD, 100, 100);
    issue(CMD_QUERY, 100, 1);
    issue(CMD_QUERY, 100, 100);
    issue(CMD_LOAD, 101, 100);
    issue(CMD_QUERY, 101, 1);
    issue(CMD_QUERY, 101, 100);
    issue(CMD_QUERY, 101, 2);

    // Random part in three idling phases: sender lighter than receiver, then
    // the reverse, then full rate with one long receiver hold-off.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 32;
          rx_idle_pct = 48;
        end
        1: begin
          tx_idle_pct = 48;
          rx_idle_pct = 32;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_req    = 1'b1;
        end
      endcase
      n = 0;
      while (n < 280) begin
        random_item(counted);
        n += counted;
      end
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;

    // Wait for every answer, then a little longer so a stray transfer
    // would still be seen.
    while (pending_count != 0) @(negedge clk);
    repeat (4 * DEF_LIFT_LEVELS + 10) @(negedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
